[rtl/ierr_pkg.sv]
// ---------------------------------------------------------------------------
// ierr_pkg
// Shared types, constants and helpers for the ICMP echo reply rewriter.
// ---------------------------------------------------------------------------
package ierr_pkg;

    localparam logic [7:0] ECHO_REQUEST_TYPE = 8'd8;
    localparam int         HEADER_BYTES      = 4;
    localparam int         RESULT_Q_DEPTH    = 4;   // must be 3 or more

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_CSUM_ERR = 2'd1,
        VERDICT_NOT_ECHO = 2'd2,
        VERDICT_SHORT    = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_final;
        verdict_t   verdict;
    } result_t;

    // up to two results produced by one input beat
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

[rtl/ierr_proc.sv]
// ---------------------------------------------------------------------------
// ierr_proc
// Per-byte header rewrite, checksum update and running sum check.
// ---------------------------------------------------------------------------
module ierr_proc
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           data_byte,
    input  logic                 is_final,
    output ierr_pkg::push_t      push
);
    import ierr_pkg::*;

    localparam logic [2:0] POS_TYPE    = 3'd0;
    localparam logic [2:0] POS_CODE    = 3'd1;
    localparam logic [2:0] POS_CSUM_HI = 3'd2;
    localparam logic [2:0] POS_CSUM_LO = 3'd3;
    localparam logic [2:0] POS_SAT     = 3'(HEADER_BYTES);

    logic [2:0]  pos_reg;
    logic        odd_reg;
    logic [15:0] sum_reg;
    logic [7:0]  type_reg;
    logic [7:0]  code_reg;
    logic [7:0]  held_reg;

    logic [15:0] sum_next;
    logic [15:0] hc;
    logic [15:0] mc;
    logic [15:0] upd;
    logic [15:0] new_csum;
    verdict_t    verdict;

    always_comb
    begin
        sum_next = oc_add(sum_reg, odd_reg ? {8'h00, data_byte} : {data_byte, 8'h00});
        hc       = {held_reg, data_byte};
        mc       = {type_reg, code_reg};
        upd      = oc_add(~hc, ~mc);
        new_csum = ~upd;

        // priority: short, bad checksum, not a request
        if (pos_reg < POS_CSUM_LO)
            verdict = VERDICT_SHORT;
        else if (sum_next != 16'hFFFF)
            verdict = VERDICT_CSUM_ERR;
        else if (type_reg != ECHO_REQUEST_TYPE)
            verdict = VERDICT_NOT_ECHO;
        else
            verdict = VERDICT_OK;

        push        = '0;
        push.first  = '{reply_byte: data_byte, reply_final: 1'b0, verdict: VERDICT_OK};
        push.second = '{reply_byte: data_byte, reply_final: 1'b0, verdict: VERDICT_OK};

        case (pos_reg) inside
            POS_TYPE, POS_CODE:
            begin
                push.count            = 2'd1;
                push.first.reply_byte = 8'h00;   // reply type and code are zero
            end
            POS_CSUM_HI:
            begin
                // held until the low byte arrives, unless message ends here
                push.count            = is_final ? 2'd1 : 2'd0;
                push.first.reply_byte = 8'h00;
            end
            POS_CSUM_LO:
            begin
                push.count             = 2'd2;
                push.first.reply_byte  = new_csum[15:8];
                push.second.reply_byte = new_csum[7:0];
            end
            default:
            begin
                push.count = 2'd1;
            end
        endcase

        if (is_final)
        begin
            if (push.count == 2'd2)
            begin
                push.second.reply_final = 1'b1;
                push.second.verdict     = verdict;
            end
            else
            begin
                push.first.reply_final = 1'b1;
                push.first.verdict     = verdict;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            odd_reg  <= 1'b0;
            sum_reg  <= '0;
            type_reg <= '0;
            code_reg <= '0;
            held_reg <= '0;
        end
        else if (advance)
        begin
            if (is_final)
            begin
                pos_reg  <= '0;
                odd_reg  <= 1'b0;
                sum_reg  <= '0;
                type_reg <= '0;
                code_reg <= '0;
                held_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                odd_reg <= ~odd_reg;
                if (pos_reg < POS_SAT)
                    pos_reg <= pos_reg + 3'd1;
                if (pos_reg == POS_TYPE)
                    type_reg <= data_byte;
                if (pos_reg == POS_CODE)
                    code_reg <= data_byte;
                if (pos_reg == POS_CSUM_HI)
                    held_reg <= data_byte;
            end
        end
    end

endmodule

[rtl/ierr_fifo.sv]
// ---------------------------------------------------------------------------
// ierr_fifo
// Result queue: up to two results in a cycle, one out a cycle unless stalled.
// ---------------------------------------------------------------------------
module ierr_fifo
#(
    parameter int DEPTH = ierr_pkg::RESULT_Q_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  ierr_pkg::push_t   push,
    output logic              space,
    output logic              out_valid,
    input  logic              out_stall,
    output ierr_pkg::result_t head
);
    import ierr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wr_ptr_p1;
    logic [1:0]         n_push;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign space     = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign n_push    = push_en ? push.count : 2'd0;
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        case (n_push)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_p1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (n_push == 2'd2)
            mem[wr_ptr_p1] <= push.second;
    end

endmodule

[rtl/icmp_echo_reply_rewriter.sv]
// ---------------------------------------------------------------------------
// icmp_echo_reply_rewriter
// Turns a received ICMP echo request, one byte per beat, into the echo reply
// byte stream with an incrementally updated checksum and a final verdict.
// ---------------------------------------------------------------------------
// Usage: feed the ICMP message one byte per beat, is_final on the last byte.
// Each input beat yields one reply beat, except that the received checksum
// high byte (byte 2) yields nothing unless final and byte 3 yields both new
// checksum bytes, so a message of four bytes or more gives as many reply
// beats as it has bytes. The reply has type 0, code 0, a checksum updated
// for the zeroed type/code word, and bytes 4 on copied verbatim. The beat with
// reply_final carries the verdict: 0 reply valid, 1 checksum error
// (ones-complement sum of the whole message, odd tail padded with zero, is
// not 0xFFFF), 2 not an echo request, 3 shorter than four bytes; verdict
// reads 0 on other beats. Non-request messages are still rewritten; drop
// them on verdict 2. Throughput is one byte per clock sustained, input and
// output both, while the output is not stalled; an accepted byte passes the
// input register, then a four-entry result queue, before its first reply
// beat. The queue takes a byte from the input register only while it has
// two free entries, since byte 3 pushes two results at once; that is the
// only source of input stall besides a stalled output.
// ---------------------------------------------------------------------------
module icmp_echo_reply_rewriter
#(
    parameter int RESULT_Q_DEPTH = ierr_pkg::RESULT_Q_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       is_final,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] reply_byte,
    output logic       reply_final,
    output logic [1:0] verdict
);
    import ierr_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] data_reg;
    logic       final_reg;

    logic       q_space;
    logic       advance;
    logic       accept;
    push_t      push;
    result_t    head;

    // registered item moves into the queue when two entries are free
    assign advance  = in_valid_reg && q_space;
    assign in_stall = in_valid_reg && !q_space;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg  <= data_byte;
            final_reg <= is_final;
        end
    end

    // header rewrite and checksum logic
    ierr_proc u_proc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (data_reg),
        .is_final  (final_reg),
        .push      (push)
    );

    // result queue doubles as the output register
    ierr_fifo #(.DEPTH(RESULT_Q_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .space     (q_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign reply_byte  = head.reply_byte;
    assign reply_final = head.reply_final;
    assign verdict     = head.verdict;

endmodule

[rtl/ierr_checker.sv]
// ---------------------------------------------------------------------------
// ierr_checker
// Port-level checks for the echo reply rewriter, bound to the top level.
// ---------------------------------------------------------------------------
module ierr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] reply_byte,
    input logic       reply_final,
    input logic [1:0] verdict
);
    import ierr_pkg::*;

    // stalled beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // stalled beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(reply_byte) && $stable(reply_final) && $stable(verdict))
        else $error("output payload changed while stalled");

    // verdict only on the closing beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reply_final |-> verdict == VERDICT_OK)
        else $error("verdict set on a non-final beat");

    // a short message ends on a zeroed header byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_final && verdict == VERDICT_SHORT |-> reply_byte == 8'h00)
        else $error("short message closed with nonzero byte");

endmodule

bind icmp_echo_reply_rewriter ierr_checker u_ierr_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reply_byte  (reply_byte),
    .reply_final (reply_final),
    .verdict     (verdict)
);

[tb/sv/icmp_echo_reply_rewriter_tb.sv]
// ---------------------------------------------------------------------------
// icmp_echo_reply_rewriter_tb
// Self-checking bench for the ICMP echo reply rewriter. A short table of
// directed messages covers the short-message verdicts, the all-ones bytes, a
// clean echo request, an odd-length non-request and a bad checksum. Random
// messages follow; most are well formed with random content and a correct
// checksum, and the rest are corrupted, short or pure noise. Every accepted
// input beat runs through a cycle-free model of the rewriter, and each reply
// beat is checked in order against the model's or directed table's replies.
// ---------------------------------------------------------------------------
module icmp_echo_reply_rewriter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ierr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 500;
    localparam int QUIET_AFTER  = 420;   // no idling on either side after this
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_MSG      = 48;
    localparam int PAUSE_EVERY  = 25;    // messages between full drains
    localparam int DIR_ROWS     = 23;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        result_t    want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       is_final;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] reply_byte;
    logic       reply_final;
    logic [1:0] verdict;

    // reply beats still owed by the block, oldest first
    result_t     pending_replies [$];
    stim_row_t   dir_rows [DIR_ROWS];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int unsigned cycles     = 0;
    int          stall_left = 0;
    bit          quiet      = 1'b0;  // set for the last stretch: no idling
    bit          idle_on    = 1'b1;  // cleared per message for idle-free runs

    // model state, mirrors the block's registers
    logic [2:0]  msg_pos    = '0;    // bytes seen, saturates at the header size
    logic        low_half   = 1'b0;  // next byte is the low byte of a word
    logic [15:0] csum_acc   = '0;    // ones-complement sum of the message
    logic [7:0]  seen_type  = '0;
    logic [7:0]  seen_code  = '0;
    logic [7:0]  cs_hi_hold = '0;    // received checksum high byte

    icmp_echo_reply_rewriter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .is_final    (is_final),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reply_byte  (reply_byte),
        .reply_final (reply_final),
        .verdict     (verdict)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // 16-bit ones-complement add, carry folded back in
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = 17'(a) + 17'(b);
        return s[15:0] + 16'(s[16]);
    endfunction

    // Advance the model by one input byte; returns the reply beats it causes.
    task automatic step_reply_model(input logic [7:0] b, input logic fin,
                                    output int n, output result_t r0, output result_t r1);
        logic [2:0]  pos;
        logic [15:0] hc;
        logic [15:0] tc;
        logic [15:0] nc;
        result_t     res [2];
        verdict_t    v;
        pos    = msg_pos;
        n      = 0;
        res[0] = '0;
        res[1] = '0;

        csum_acc = ones_add(csum_acc, low_half ? {8'h00, b} : {b, 8'h00});
        low_half = ~low_half;

        case (pos)
            3'd0:
            begin
                seen_type = b;
                res[0].reply_byte = 8'h00;
                n = 1;
            end
            3'd1:
            begin
                seen_code = b;
                res[0].reply_byte = 8'h00;
                n = 1;
            end
            3'd2:
            begin
                // checksum high byte is held; only a message ending here replies
                cs_hi_hold = b;
                if (fin)
                begin
                    res[0].reply_byte = 8'h00;
                    n = 1;
                end
            end
            3'd3:
            begin
                // incremental update for type/code word going to zero
                hc = {cs_hi_hold, b};
                tc = {seen_type, seen_code};
                nc = ~ones_add(~hc, ~tc);
                res[0].reply_byte = nc[15:8];
                res[1].reply_byte = nc[7:0];
                n = 2;
            end
            default:
            begin
                res[0].reply_byte = b;
                n = 1;
            end
        endcase

        if (msg_pos < HEADER_BYTES)
            msg_pos = msg_pos + 3'd1;

        if (fin)
        begin
            // priority: too short, bad checksum, not a request
            if (int'(pos) + 1 < HEADER_BYTES)
                v = VERDICT_SHORT;
            else if (csum_acc != 16'hFFFF)
                v = VERDICT_CSUM_ERR;
            else if (seen_type != ECHO_REQUEST_TYPE)
                v = VERDICT_NOT_ECHO;
            else
                v = VERDICT_OK;
            res[n-1].reply_final = 1'b1;
            res[n-1].verdict     = v;
            msg_pos    = '0;
            low_half   = 1'b0;
            csum_acc   = '0;
            seen_type  = '0;
            seen_code  = '0;
            cs_hi_hold = '0;
        end
        r0 = res[0];
        r1 = res[1];
    endtask

    // Drive one input beat, wait for it to be taken, then queue its replies.
    // Called in the time step of the previous accept (or after reset), so
    // in_valid gets a single assignment per step.
    task automatic send_beat(input logic [7:0] b, input logic fin,
                             input logic typed, input result_t want);
        int      n;
        result_t r0;
        result_t r1;
        if (!quiet && idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_final  <= fin;
        do
            @(posedge clk);
        while (in_stall);
        step_reply_model(b, fin, n, r0, r1);
        if (typed)
            pending_replies.push_back(want);
        else
        begin
            if (n > 0)
                pending_replies.push_back(r0);
            if (n > 1)
                pending_replies.push_back(r1);
        end
        bytes_sent++;
    endtask

    // Output side: check each accepted reply beat, then pick the next stall.
    // Values are read right after the edge, before any update lands.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: stray reply beat: expected none, got %h/%b/%0d",
                         $time, reply_byte, reply_final, verdict);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (reply_byte !== want.reply_byte)
                begin
                    mismatches++;
                    $display("%0t: reply_byte expected %h got %h",
                             $time, want.reply_byte, reply_byte);
                end
                if (reply_final !== want.reply_final)
                begin
                    mismatches++;
                    $display("%0t: reply_final expected %b got %b",
                             $time, want.reply_final, reply_final);
                end
                if (verdict !== want.verdict)
                begin
                    mismatches++;
                    $display("%0t: verdict expected %0d got %0d",
                             $time, want.verdict, verdict);
                end
            end
        end

        // random output stall bursts
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]  msg [MAX_MSG];
        logic [15:0] acc;
        int          len;
        int          kind;
        int          i;
        int          msg_count;

        in_valid  = 1'b0;
        data_byte = 8'h00;
        is_final  = 1'b0;
        rst_n     = 1'b0;
        msg_count = 0;

        // Directed messages. Short ones carry their replies inline: header
        // bytes always come back as zero and a short end is verdict 3.
        dir_rows = '{
            // lone type byte
            '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, VERDICT_SHORT}},
            // two all-ones bytes
            '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, VERDICT_OK}},
            '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, VERDICT_SHORT}},
            // ends on the held checksum high byte
            '{8'h08, 1'b0, 1'b1, '{8'h00, 1'b0, VERDICT_OK}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, VERDICT_OK}},
            '{8'h55, 1'b1, 1'b1, '{8'h00, 1'b1, VERDICT_SHORT}},
            // clean echo request, even length
            '{8'h08, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hF7, 1'b0, 1'b0, '0},
            '{8'hFD, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b1, 1'b0, '0},
            // type 0 with good checksum, odd tail padded with zero
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h54, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hAB, 1'b1, 1'b0, '0},
            // four bytes, checksum wrong, final lands on the second new byte
            '{8'h08, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);

        // Random messages until the byte budget is spent.
        while (bytes_sent < DIR_ROWS + RANDOM_BYTES)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            quiet   = (bytes_sent >= DIR_ROWS + QUIET_AFTER);
            kind    = $urandom_range(0, 9);

            if (kind <= 6)
            begin
                // well-formed message; mostly short, now and then long
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(HEADER_BYTES, MAX_MSG);
                else
                    len = $urandom_range(HEADER_BYTES, 12);
                for (i = 0; i < len; i++)
                    msg[i] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0)
                    msg[0] = ECHO_REQUEST_TYPE;
                if ($urandom_range(0, 1) != 0)
                    msg[1] = 8'h00;
                msg[2] = 8'h00;
                msg[3] = 8'h00;
                acc = '0;
                for (i = 0; i < len; i += 2)
                    acc = ones_add(acc, {msg[i], (i + 1 < len) ? msg[i+1] : 8'h00});
                {msg[2], msg[3]} = ~acc;
                // one in seven gets a flipped bit somewhere
                if (kind == 6)
                begin
                    i = $urandom_range(0, len - 1);
                    msg[i] = msg[i] ^ (8'h01 << $urandom_range(0, 7));
                end
            end
            else
            begin
                // short or pure noise
                len = (kind == 7) ? $urandom_range(1, HEADER_BYTES - 1) : $urandom_range(1, 20);
                for (i = 0; i < len; i++)
                    msg[i] = 8'($urandom_range(0, 255));
            end

            for (i = 0; i < len; i++)
                send_beat(msg[i], (i == len - 1), 1'b0, '0);
            msg_count++;

            // sender holds off until the block has answered everything
            if (msg_count % PAUSE_EVERY == 0)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_replies.size() != 0);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
        // catch stray beats past the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/ierr_pkg.sv
rtl/ierr_proc.sv
rtl/ierr_fifo.sv
rtl/icmp_echo_reply_rewriter.sv
rtl/ierr_checker.sv
tb/sv/icmp_echo_reply_rewriter_tb.sv
